// ===== src/asla_pkg.sv =====
// Shared types, constants and helpers for the analog scale and level alarm block.
package asla_pkg;

  // Converter and persistence limits
  localparam int ADC_BITS          = 12;
  localparam int HIGH_RED_LIMIT    = 16;
  localparam int HIGH_YELLOW_LIMIT = 16;
  localparam int LOW_RED_LIMIT     = 16;
  localparam int LOW_YELLOW_LIMIT  = 16;

  // Field widths
  localparam int RAW_W    = 12;
  localparam int GAIN_W   = 11;
  localparam int OFFSET_W = 16;
  localparam int ENG_W    = 24;
  localparam int CNT_W    = 8;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Only the low converter bits of a sample are used
  localparam int RAW_USE = (ADC_BITS < RAW_W) ? ADC_BITS : RAW_W;
  localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((1 << RAW_USE) - 1);

  // Saturation bounds, one bit wider than the result
  localparam logic signed [ENG_W:0] ENG_MAX = (ENG_W+1)'((1 << (ENG_W-1)) - 1);
  localparam logic signed [ENG_W:0] ENG_MIN = -(ENG_W+1)'(1 << (ENG_W-1));

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN        = 3'd0,
    REG_OFFSET      = 3'd1,
    REG_LOW_RED     = 3'd2,
    REG_LOW_YELLOW  = 3'd3,
    REG_HIGH_YELLOW = 3'd4,
    REG_HIGH_RED    = 3'd5
  } cfg_reg_t;

  // Alarm status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_NOMINAL     = 3'd0,
    ST_HIGH_YELLOW = 3'd1,
    ST_HIGH_RED    = 3'd2,
    ST_LOW_YELLOW  = 3'd3,
    ST_LOW_RED     = 3'd4
  } status_t;

  // Configuration register contents
  typedef struct packed {
    logic signed [GAIN_W-1:0]   gain;
    logic signed [OFFSET_W-1:0] offset;
    logic signed [ENG_W-1:0]    low_red_level;
    logic signed [ENG_W-1:0]    low_yellow_level;
    logic signed [ENG_W-1:0]    high_yellow_level;
    logic signed [ENG_W-1:0]    high_red_level;
  } cfg_t;

  // Scaled value word between the scale and alarm stages
  typedef struct packed {
    logic                    valid;
    logic signed [ENG_W-1:0] value;
  } eng_word_t;

  // Counter step result
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             alarm;
  } persist_t;

  // Saturating up/down persistence counter step
  function automatic persist_t persist_step(input logic [CNT_W-1:0] cnt,
                                            input logic beyond,
                                            input logic [CNT_W-1:0] limit);
    persist_t r;
    r.count = cnt;
    r.alarm = 1'b0;
    if (beyond) begin
      if (cnt >= limit) begin
        r.count = limit;
        r.alarm = 1'b1;
      end else begin
        r.count = cnt + CNT_W'(1);
      end
    end else if (cnt != '0) begin
      r.count = cnt - CNT_W'(1);
      if (r.count > limit) begin
        r.count = limit;
      end
    end
    return r;
  endfunction

endpackage

// ===== src/asla_if.sv =====
// Valid/ready channel interfaces for samples and results.
interface asla_sample_if
  import asla_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface asla_result_if
  import asla_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [ENG_W-1:0]    eng_value;
  logic [STATUS_W-1:0] alarm_status;

  modport source (output valid, output eng_value, output alarm_status, input ready);
  modport sink   (input valid, input eng_value, input alarm_status, output ready);
endinterface

// ===== src/asla_cfg.sv =====
// Configuration register file with a plain write port.
module asla_cfg
  import asla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN:        cfg.gain              <= cfg_data[GAIN_W-1:0];
        REG_OFFSET:      cfg.offset            <= cfg_data[OFFSET_W-1:0];
        REG_LOW_RED:     cfg.low_red_level     <= cfg_data[ENG_W-1:0];
        REG_LOW_YELLOW:  cfg.low_yellow_level  <= cfg_data[ENG_W-1:0];
        REG_HIGH_YELLOW: cfg.high_yellow_level <= cfg_data[ENG_W-1:0];
        REG_HIGH_RED:    cfg.high_red_level    <= cfg_data[ENG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/asla_scale.sv =====
// Input register and gain/offset scaling stage with saturation.
module asla_scale
  import asla_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  asla_sample_if.sink   in_ch,
  input  cfg_t          cfg,
  output eng_word_t     eng,
  input  logic          eng_ready
);

  logic             s1_valid;
  logic [RAW_W-1:0] s1_raw;
  logic             s1_ready;
  logic             s2_ready;
  logic             s2_load;

  logic signed [ENG_W-1:0] raw_w;
  logic signed [ENG_W-1:0] gain_w;
  logic signed [ENG_W-1:0] prod;
  logic signed [ENG_W:0]   sum;
  logic signed [ENG_W-1:0] sat;

  // Stage handshake
  assign s2_ready    = !eng.valid || eng_ready;
  assign s2_load     = s1_valid && s2_ready;
  assign s1_ready    = !s1_valid || s2_load;
  assign in_ch.ready = s1_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && s1_ready) begin
      s1_raw <= in_ch.raw_sample & RAW_MASK;
    end
  end

  // raw * gain + offset, or raw when gain is zero
  assign raw_w  = ENG_W'(s1_raw);
  assign gain_w = ENG_W'(cfg.gain);
  assign prod   = raw_w * gain_w;

  always_comb begin
    if (cfg.gain != '0) begin
      sum = (ENG_W+1)'(prod) + (ENG_W+1)'(cfg.offset);
    end else begin
      sum = (ENG_W+1)'(raw_w);
    end
  end

  // Clamp to the result range
  always_comb begin
    if (sum > ENG_MAX) begin
      sat = ENG_MAX[ENG_W-1:0];
    end else if (sum < ENG_MIN) begin
      sat = ENG_MIN[ENG_W-1:0];
    end else begin
      sat = sum[ENG_W-1:0];
    end
  end

  // Scaled value register
  always_ff @(posedge clk) begin
    if (rst) begin
      eng.valid <= 1'b0;
    end else if (s2_ready) begin
      eng.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      eng.value <= sat;
    end
  end

endmodule

// ===== src/asla_alarm.sv =====
// Threshold compares, persistence counters, alarm priority and result register.
module asla_alarm
  import asla_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  eng_word_t      eng,
  output logic           eng_ready,
  input  cfg_t           cfg,
  asla_result_if.source  out_ch
);

  logic [CNT_W-1:0] high_red_count;
  logic [CNT_W-1:0] high_yellow_count;
  logic [CNT_W-1:0] low_red_count;
  logic [CNT_W-1:0] low_yellow_count;

  persist_t hr_next;
  persist_t hy_next;
  persist_t lr_next;
  persist_t ly_next;
  status_t  status_next;
  logic     load;

  // Result register takes a word when empty or being drained
  assign eng_ready = !out_ch.valid || out_ch.ready;
  assign load      = eng.valid && eng_ready;

  // Counter steps against each level
  assign hr_next = persist_step(high_red_count, eng.value > cfg.high_red_level,
                                CNT_W'(HIGH_RED_LIMIT));
  assign hy_next = persist_step(high_yellow_count, eng.value > cfg.high_yellow_level,
                                CNT_W'(HIGH_YELLOW_LIMIT));
  assign lr_next = persist_step(low_red_count, eng.value < cfg.low_red_level,
                                CNT_W'(LOW_RED_LIMIT));
  assign ly_next = persist_step(low_yellow_count, eng.value < cfg.low_yellow_level,
                                CNT_W'(LOW_YELLOW_LIMIT));

  // Priority: low red, low yellow, high red, high yellow
  always_comb begin
    if (lr_next.alarm) begin
      status_next = ST_LOW_RED;
    end else if (ly_next.alarm) begin
      status_next = ST_LOW_YELLOW;
    end else if (hr_next.alarm) begin
      status_next = ST_HIGH_RED;
    end else if (hy_next.alarm) begin
      status_next = ST_HIGH_YELLOW;
    end else begin
      status_next = ST_NOMINAL;
    end
  end

  // Persistence counters advance once per word
  always_ff @(posedge clk) begin
    if (rst) begin
      high_red_count    <= '0;
      high_yellow_count <= '0;
      low_red_count     <= '0;
      low_yellow_count  <= '0;
    end else if (load) begin
      high_red_count    <= hr_next.count;
      high_yellow_count <= hy_next.count;
      low_red_count     <= lr_next.count;
      low_yellow_count  <= ly_next.count;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (eng_ready) begin
      out_ch.valid <= eng.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.eng_value    <= eng.value;
      out_ch.alarm_status <= status_next;
    end
  end

endmodule

// ===== src/analog_scale_and_level_alarm_top.sv =====
// Each sample word passes an input register, a scaling stage (one 12x11 multiply, offset
// add and saturation) and an alarm stage (four level compares, persistence counters and
// priority encode) before landing in the result register. One word is accepted every
// cycle while the result side does not stall. The multiply-add stage and the counter
// update set the cycle time. The output is fully registered, so a stalled result only
// holds the pipeline once all three stages are full. The user must write configuration
// registers through the plain write port while the block is idle; this is not enforced.
module analog_scale_and_level_alarm_top
  import asla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  asla_sample_if.sink           in_ch,
  asla_result_if.source         out_ch
);

  cfg_t      cfg;
  eng_word_t eng;
  logic      eng_ready;

  // Configuration registers
  asla_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Scaling stage
  asla_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .eng       (eng),
    .eng_ready (eng_ready)
  );

  // Alarm stage and result register
  asla_alarm u_alarm (
    .clk       (clk),
    .rst       (rst),
    .eng       (eng),
    .eng_ready (eng_ready),
    .cfg       (cfg),
    .out_ch    (out_ch)
  );

endmodule

// ===== src/asla_checker.sv =====
// Port-level checks for the analog scale and level alarm block, bound to the top level.
module asla_checker
  import asla_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [ENG_W-1:0]    eng_value,
  input logic [STATUS_W-1:0] alarm_status
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // Status code stays within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (alarm_status <= STATUS_W'(ST_LOW_RED)))
    else $error("alarm status out of range");

  // With no result pending the input side is never stalled
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(eng_value) && $stable(alarm_status))
    else $error("stalled result changed");

endmodule

bind analog_scale_and_level_alarm_top asla_checker u_asla_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .eng_value    (out_ch.eng_value),
  .alarm_status (out_ch.alarm_status)
);
